/* sv/spq_pkg.sv */
package spq_pkg;

    // Number of entries the queue holds
    localparam int CAPACITY = 16;
    // Internal fill count, wide enough to hold CAPACITY itself
    localparam int CNT_W    = $clog2(CAPACITY + 1);

    // Transaction field widths
    localparam int CMD_W    = 2;
    localparam int DATA_W   = 32;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 5;

    typedef enum logic [CMD_W-1:0] {
        CMD_INSERT  = 2'd0,
        CMD_EXTRACT = 2'd1,
        CMD_PEEK    = 2'd2,
        CMD_MODIFY  = 2'd3
    } t_cmd;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK       = 2'd0,
        ST_EMPTY    = 2'd1,
        ST_FULL     = 2'd2,
        ST_NOTFOUND = 2'd3
    } t_status;

    // One queue entry
    typedef struct packed {
        logic signed [DATA_W-1:0] value;
        logic signed [DATA_W-1:0] prio;
    } t_entry;

    // What every cell does in a cycle
    typedef enum logic [1:0] {
        CO_HOLD,
        CO_INSERT,
        CO_POP,
        CO_DELETE
    } t_cell_op;

    // Broadcast from the controller to the whole row
    typedef struct packed {
        t_cell_op op;
        t_entry   item;
    } t_cell_ctrl;

endpackage

/* sv/spq_if.sv */
// Input channel: one command transaction
interface spq_in_if;
    logic                                valid;
    logic                                ready;
    logic [spq_pkg::CMD_W-1:0]           command;
    logic signed [spq_pkg::DATA_W-1:0]   item_value;
    logic signed [spq_pkg::DATA_W-1:0]   item_priority;

    modport source (output valid, output command, output item_value,
                    output item_priority, input ready);
    modport sink   (input valid, input command, input item_value,
                    input item_priority, output ready);
endinterface

// Output channel: one result transaction
interface spq_out_if;
    logic                                valid;
    logic                                ready;
    logic signed [spq_pkg::DATA_W-1:0]   out_value;
    logic [spq_pkg::STATUS_W-1:0]        status;
    logic [spq_pkg::COUNT_W-1:0]         count;

    modport source (output valid, output out_value, output status,
                    output count, input ready);
    modport sink   (input valid, input out_value, input status,
                    input count, output ready);
endinterface

/* sv/sorted_priority_queue.sv */
// Sorted priority queue, held in a row of cells in descending priority order.
// Input channel i_in carries command, item_value and item_priority; output
// channel o_out returns out_value, status and count, one result transaction
// for every input transaction, in order.
// Equal priorities leave first in, first out.
// Insert, extract and peek first capture the transaction; then every cell
// shifts or holds and the result register loads.
// Modify adds a step between these in which the cells close the gap at the
// first matching value, before the reinsert step.
// The result turns valid when the update step loads the output register, and
// the receiver can take it from then on.
// A new transaction is accepted only in the idle state, so the block does not
// take one before the cell row has finished the update for the last one.
// Reset empties the queue and the output register; cell contents are not
// cleared and are never read before written.
// When the receiver stalls, the result and its count wait in the output
// register; one more transaction is accepted and holds before its update
// until the output slot frees (a modify may still close its gap meanwhile).
module sorted_priority_queue (
    input  logic     i_clk,
    input  logic     i_rst_n,
    spq_in_if.sink   i_in,
    spq_out_if.source o_out
);

    typedef enum logic [2:0] {
        S_IDLE   = 3'b001,
        S_DELETE = 3'b010,
        S_EXEC   = 3'b100
    } t_state;

    t_state                            r_state, n_state;
    logic [spq_pkg::CNT_W-1:0]         r_count, n_count;
    spq_pkg::t_cmd                     r_cmd;
    spq_pkg::t_entry                   r_item;
    logic                              r_found, n_found;

    logic                              r_out_valid, n_out_valid;
    logic signed [spq_pkg::DATA_W-1:0] r_out_value, n_out_value;
    spq_pkg::t_status                  r_out_status, n_out_status;
    logic [spq_pkg::COUNT_W-1:0]       r_out_count, n_out_count;

    spq_pkg::t_cell_ctrl               w_ctrl;
    spq_pkg::t_entry                   w_entry [spq_pkg::CAPACITY];
    logic                              w_ge    [spq_pkg::CAPACITY];
    logic                              w_hit   [spq_pkg::CAPACITY];
    logic                              w_occ   [spq_pkg::CAPACITY];
    logic                              w_found;
    logic                              w_out_free;
    logic                              w_accept;

    assign i_in.ready      = (r_state == S_IDLE);
    assign w_accept        = i_in.valid && i_in.ready;
    assign w_out_free      = !r_out_valid || o_out.ready;
    assign w_found         = w_hit[spq_pkg::CAPACITY-1];

    assign o_out.valid     = r_out_valid;
    assign o_out.out_value = r_out_value;
    assign o_out.status    = r_out_status;
    assign o_out.count     = r_out_count;

    // Build the row of cells
    genvar gi;
    generate
        for (gi = 0; gi < spq_pkg::CAPACITY; gi++) begin : g_cell
            assign w_occ[gi] = (spq_pkg::CNT_W'(gi) < r_count);
            if (gi == 0) begin : g_head
                spq_cell u_cell (
                    .i_clk      (i_clk),
                    .i_ctrl     (w_ctrl),
                    .i_occ      (w_occ[gi]),
                    .i_left     (w_ctrl.item),
                    .i_left_ge  (1'b1),
                    .i_left_hit (1'b0),
                    .i_right    (w_entry[gi+1]),
                    .o_entry    (w_entry[gi]),
                    .o_ge       (w_ge[gi]),
                    .o_hit      (w_hit[gi])
                );
            end else if (gi == spq_pkg::CAPACITY-1) begin : g_tail
                spq_cell u_cell (
                    .i_clk      (i_clk),
                    .i_ctrl     (w_ctrl),
                    .i_occ      (w_occ[gi]),
                    .i_left     (w_entry[gi-1]),
                    .i_left_ge  (w_ge[gi-1]),
                    .i_left_hit (w_hit[gi-1]),
                    .i_right    (w_entry[gi]),
                    .o_entry    (w_entry[gi]),
                    .o_ge       (w_ge[gi]),
                    .o_hit      (w_hit[gi])
                );
            end else begin : g_mid
                spq_cell u_cell (
                    .i_clk      (i_clk),
                    .i_ctrl     (w_ctrl),
                    .i_occ      (w_occ[gi]),
                    .i_left     (w_entry[gi-1]),
                    .i_left_ge  (w_ge[gi-1]),
                    .i_left_hit (w_hit[gi-1]),
                    .i_right    (w_entry[gi+1]),
                    .o_entry    (w_entry[gi]),
                    .o_ge       (w_ge[gi]),
                    .o_hit      (w_hit[gi])
                );
            end
        end
    endgenerate

    // Sequence the row and load the result register
    always_comb begin
        n_state      = r_state;
        n_count      = r_count;
        n_found      = r_found;
        n_out_valid  = r_out_valid && !o_out.ready;
        n_out_value  = r_out_value;
        n_out_status = r_out_status;
        n_out_count  = r_out_count;
        w_ctrl.op    = spq_pkg::CO_HOLD;
        w_ctrl.item  = r_item;

        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_state = (spq_pkg::t_cmd'(i_in.command) == spq_pkg::CMD_MODIFY)
                              ? S_DELETE : S_EXEC;
                end
            end
            S_DELETE: begin
                w_ctrl.op = spq_pkg::CO_DELETE;
                n_found   = w_found;
                if (w_found) begin
                    n_count = r_count - 1'b1;
                end
                n_state = S_EXEC;
            end
            S_EXEC: begin
                if (w_out_free) begin
                    n_out_valid  = 1'b1;
                    n_out_value  = '0;
                    n_out_status = spq_pkg::ST_OK;
                    n_state      = S_IDLE;
                    case (r_cmd)
                        spq_pkg::CMD_INSERT: begin
                            if (r_count == spq_pkg::CNT_W'(spq_pkg::CAPACITY)) begin
                                n_out_status = spq_pkg::ST_FULL;
                            end else begin
                                w_ctrl.op = spq_pkg::CO_INSERT;
                                n_count   = r_count + 1'b1;
                            end
                        end
                        spq_pkg::CMD_EXTRACT, spq_pkg::CMD_PEEK: begin
                            if (r_count == '0) begin
                                n_out_status = spq_pkg::ST_EMPTY;
                            end else begin
                                n_out_value = w_entry[0].value;
                                if (r_cmd == spq_pkg::CMD_EXTRACT) begin
                                    w_ctrl.op = spq_pkg::CO_POP;
                                    n_count   = r_count - 1'b1;
                                end
                            end
                        end
                        spq_pkg::CMD_MODIFY: begin
                            if (r_found) begin
                                w_ctrl.op = spq_pkg::CO_INSERT;
                                n_count   = r_count + 1'b1;
                            end else begin
                                n_out_status = spq_pkg::ST_NOTFOUND;
                            end
                        end
                        default: begin
                            n_out_status = spq_pkg::ST_OK;
                        end
                    endcase
                    // Hold the count left by this update with its result
                    n_out_count = spq_pkg::COUNT_W'(n_count);
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_cmd       <= spq_pkg::t_cmd'(i_in.command);
            r_item.value <= i_in.item_value;
            r_item.prio  <= i_in.item_priority;
        end
        r_found      <= n_found;
        r_out_value  <= n_out_value;
        r_out_status <= n_out_status;
        r_out_count  <= n_out_count;
    end

    // Fill count never exceeds capacity
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= spq_pkg::CNT_W'(spq_pkg::CAPACITY))
        else $error("fill count above capacity");

    // A failed search leaves the fill count alone
    a_miss_keeps_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DELETE && !w_found) |=> (r_count == $past(r_count)))
        else $error("fill count changed on missed search");

    // A new result reports the count left by its own update
    a_result_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EXEC && w_out_free) |=>
            (o_out.valid && o_out.count == spq_pkg::COUNT_W'(r_count)))
        else $error("result count does not match queue");

endmodule

/* sv/spq_cell.sv */
module spq_cell (
    input  logic                i_clk,
    input  spq_pkg::t_cell_ctrl i_ctrl,
    input  logic                i_occ,
    input  spq_pkg::t_entry     i_left,
    input  logic                i_left_ge,
    input  logic                i_left_hit,
    input  spq_pkg::t_entry     i_right,
    output spq_pkg::t_entry     o_entry,
    output logic                o_ge,
    output logic                o_hit
);

    spq_pkg::t_entry r_entry;
    spq_pkg::t_entry n_entry;
    logic            w_match;

    // Compare the held entry against the broadcast item
    assign o_ge    = i_occ && ($signed(r_entry.prio) >= $signed(i_ctrl.item.prio));
    assign w_match = i_occ && (r_entry.value == i_ctrl.item.value);
    assign o_hit   = i_left_hit | w_match;
    assign o_entry = r_entry;

    // Pick the next entry from self, neighbors or the new item
    always_comb begin
        n_entry = r_entry;
        case (i_ctrl.op)
            spq_pkg::CO_HOLD: begin
                n_entry = r_entry;
            end
            spq_pkg::CO_INSERT: begin
                if (o_ge) begin
                    n_entry = r_entry;
                end else if (!i_left_ge) begin
                    n_entry = i_left;
                end else begin
                    n_entry = i_ctrl.item;
                end
            end
            spq_pkg::CO_POP: begin
                n_entry = i_right;
            end
            spq_pkg::CO_DELETE: begin
                n_entry = o_hit ? i_right : r_entry;
            end
            default: begin
                n_entry = r_entry;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end

endmodule

/* verif/spq_checker.sv */
`timescale 1ns / 100ps

// Watches both channels, predicts every result from the accepted commands,
// and compares results in order against the oldest outstanding prediction.
module spq_checker
    import spq_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    spq_in_if    i_cmd_ch,
    spq_out_if   i_res_ch,
    output int   o_errors,
    output int   o_awaiting,
    output int   o_checked,
    output int   o_full_seen,
    output int   o_empty_seen
);

    typedef struct packed {
        logic signed [DATA_W-1:0] value;
        t_status                  status;
        logic [COUNT_W-1:0]       count;
    } t_result;

    // Shadow of the queue contents, highest priority at index 0
    logic signed [DATA_W-1:0] sorted_values [CAPACITY];
    logic signed [DATA_W-1:0] sorted_prios  [CAPACITY];
    int                       held;

    t_result awaited_results [$];
    int      errors;
    int      checked;
    int      full_seen;
    int      empty_seen;

    // Close the gap at pos
    function void drop_entry(int pos);
        for (int i = pos; i + 1 < held; i++) begin
            sorted_values[i] = sorted_values[i + 1];
            sorted_prios[i]  = sorted_prios[i + 1];
        end
        held--;
    endfunction

    // Place behind every entry of greater or equal priority
    function void place_entry(logic signed [DATA_W-1:0] v, logic signed [DATA_W-1:0] p);
        int pos;
        pos = 0;
        while (pos < held && sorted_prios[pos] >= p)
            pos++;
        for (int i = held; i > pos; i--) begin
            sorted_values[i] = sorted_values[i - 1];
            sorted_prios[i]  = sorted_prios[i - 1];
        end
        sorted_values[pos] = v;
        sorted_prios[pos]  = p;
        held++;
    endfunction

    // Update the shadow queue for one command and return its result
    function t_result apply_command(t_cmd cmd, logic signed [DATA_W-1:0] v,
                                    logic signed [DATA_W-1:0] p);
        t_result r;
        int      hit;
        r.value  = '0;
        r.status = ST_OK;
        case (cmd)
            CMD_INSERT: begin
                if (held >= CAPACITY)
                    r.status = ST_FULL;
                else
                    place_entry(v, p);
            end
            CMD_EXTRACT, CMD_PEEK: begin
                if (held == 0) begin
                    r.status = ST_EMPTY;
                end else begin
                    r.value = sorted_values[0];
                    if (cmd == CMD_EXTRACT)
                        drop_entry(0);
                end
            end
            default: begin
                // First match in queue order moves to its new priority
                hit = -1;
                for (int i = 0; i < held; i++)
                    if (hit < 0 && sorted_values[i] == v)
                        hit = i;
                if (hit < 0) begin
                    r.status = ST_NOTFOUND;
                end else begin
                    drop_entry(hit);
                    place_entry(v, p);
                end
            end
        endcase
        r.count = COUNT_W'(held);
        return r;
    endfunction

    // Predict on each command transaction, compare on each result transaction
    always @(posedge i_clk) begin
        t_result got;
        t_result want;
        if (!i_rst_n) begin
            held = 0;
            awaited_results.delete();
        end else begin
            if (i_cmd_ch.valid && i_cmd_ch.ready)
                awaited_results.push_back(apply_command(t_cmd'(i_cmd_ch.command),
                                                        i_cmd_ch.item_value,
                                                        i_cmd_ch.item_priority));
            if (i_res_ch.valid && i_res_ch.ready) begin
                got.value  = i_res_ch.out_value;
                got.status = t_status'(i_res_ch.status);
                got.count  = i_res_ch.count;
                if (awaited_results.size() == 0) begin
                    errors++;
                    if (errors <= 10)
                        $display("[%0t] unexpected result: value %0d status %0d count %0d",
                                 $realtime, got.value, got.status, got.count);
                end else begin
                    want = awaited_results.pop_front();
                    checked++;
                    if (want.status == ST_FULL)
                        full_seen++;
                    if (want.status == ST_EMPTY)
                        empty_seen++;
                    if (got.value !== want.value || got.status !== want.status ||
                        got.count !== want.count) begin
                        errors++;
                        if (errors <= 10)
                            $display({"[%0t] result %0d: value exp %0d got %0d, ",
                                      "status exp %0d got %0d, count exp %0d got %0d"},
                                     $realtime, checked, want.value, got.value,
                                     want.status, got.status, want.count, got.count);
                    end
                end
            end
        end
        o_errors     <= errors;
        o_awaiting   <= awaited_results.size();
        o_checked    <= checked;
        o_full_seen  <= full_seen;
        o_empty_seen <= empty_seen;
    end

    initial begin
        held       = 0;
        errors     = 0;
        checked    = 0;
        full_seen  = 0;
        empty_seen = 0;
    end

endmodule

/* verif/sorted_priority_queue_tb.sv */
`timescale 1ns / 100ps

module sorted_priority_queue_tb;
    import spq_pkg::*;

    localparam logic signed [DATA_W-1:0] INT_MIN = 32'sh8000_0000;
    localparam logic signed [DATA_W-1:0] INT_MAX = 32'sh7FFF_FFFF;

    logic i_clk = 1'b0;
    logic i_rst_n;

    spq_in_if  cmd_ch ();
    spq_out_if res_ch ();

    int errors;
    int awaiting;
    int checked;
    int full_seen;
    int empty_seen;

    // long_hold and no_idle are shared with the result-side process
    int long_hold = 0;
    bit no_idle   = 1'b0;
    int sent_by_cmd [4];

    sorted_priority_queue uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (cmd_ch),
        .o_out   (res_ch)
    );

    spq_checker result_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd_ch     (cmd_ch),
        .i_res_ch     (res_ch),
        .o_errors     (errors),
        .o_awaiting   (awaiting),
        .o_checked    (checked),
        .o_full_seen  (full_seen),
        .o_empty_seen (empty_seen)
    );

    always #10 i_clk = ~i_clk;

    // Mostly a small pool so modify finds matches and duplicates
    function automatic logic signed [DATA_W-1:0] pick_value();
        int r;
        r = $urandom_range(0, 99);
        if (r < 75)
            return DATA_W'($urandom_range(0, 11)) - 4;
        else if (r < 80)
            return (r & 1) ? INT_MAX : INT_MIN;
        else
            return $urandom;
    endfunction

    // Mostly a narrow range so ties are common
    function automatic logic signed [DATA_W-1:0] pick_prio();
        int r;
        r = $urandom_range(0, 99);
        if (r < 65)
            return DATA_W'($urandom_range(0, 6)) - 3;
        else if (r < 75)
            return (r & 1) ? INT_MAX : INT_MIN;
        else
            return $urandom;
    endfunction

    // Offer one command transaction after a random gap, hold until accepted
    task automatic send_item(t_cmd cmd, logic signed [DATA_W-1:0] v,
                             logic signed [DATA_W-1:0] p);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 3);
        if (gap > 0) begin
            cmd_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        cmd_ch.valid         <= 1'b1;
        cmd_ch.command       <= cmd;
        cmd_ch.item_value    <= v;
        cmd_ch.item_priority <= p;
        do @(posedge i_clk); while (!cmd_ch.ready);
        sent_by_cmd[cmd]++;
    endtask

    // Stop offering and wait until every predicted result has come back
    task automatic drain_results();
        cmd_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (awaiting != 0) @(posedge i_clk);
    endtask

    // Result side: random stalls, plus one long hold-off on request
    initial begin
        int stall;
        res_ch.ready <= 1'b0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (long_hold > 0) begin
                res_ch.ready <= 1'b0;
                repeat (long_hold) @(posedge i_clk);
                long_hold = 0;
            end
            stall = no_idle ? 0 : $urandom_range(0, 3);
            if (stall > 0) begin
                res_ch.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            res_ch.ready <= 1'b1;
            do @(posedge i_clk); while (!(res_ch.valid && res_ch.ready));
        end
    end

    // Command side: directed opening, then random phases
    initial begin
        int   mix;
        int   r;
        t_cmd cmd;
        logic signed [DATA_W-1:0] v;
        logic signed [DATA_W-1:0] p;

        cmd_ch.valid         <= 1'b0;
        cmd_ch.command       <= CMD_INSERT;
        cmd_ch.item_value    <= '0;
        cmd_ch.item_priority <= '0;
        i_rst_n              <= 1'b0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Empty queue: peek, extract and modify have nothing to act on
        send_item(CMD_PEEK, INT_MAX, INT_MIN);
        send_item(CMD_EXTRACT, INT_MIN, INT_MAX);
        send_item(CMD_MODIFY, 32'sd0, 32'sd0);

        // Fill to capacity with extreme values, extreme priorities and ties
        for (int i = 0; i < CAPACITY; i++) begin
            v = (i == 0) ? INT_MAX : (i == 1) ? INT_MIN : DATA_W'(i % 4);
            p = (i == 0) ? INT_MIN : (i == 1) ? INT_MAX : DATA_W'(i % 3);
            send_item(CMD_INSERT, v, p);
        end
        send_item(CMD_INSERT, 32'sd77, INT_MAX);
        send_item(CMD_PEEK, 32'sd0, 32'sd0);

        // Duplicate value moves to the top tie; missing value is reported
        send_item(CMD_MODIFY, 32'sd2, INT_MAX);
        send_item(CMD_MODIFY, 32'sd999, 32'sd5);
        send_item(CMD_EXTRACT, 32'sd0, 32'sd0);
        send_item(CMD_EXTRACT, 32'sd0, 32'sd0);

        // Random phases: fill-heavy, drain-heavy and balanced mixes
        for (int ph = 0; ph < 12; ph++) begin
            mix     = (ph < 3) ? ph : $urandom_range(0, 2);
            no_idle = (ph == 4 || ph == 7);
            if (ph == 7)
                long_hold = 90;
            if (ph == 9)
                drain_results();
            for (int n = 0; n < 119; n++) begin
                r = $urandom_range(0, 99);
                case (mix)
                    0:       cmd = (r < 65) ? CMD_INSERT : (r < 80) ? CMD_EXTRACT :
                                   (r < 88) ? CMD_PEEK : CMD_MODIFY;
                    1:       cmd = (r < 20) ? CMD_INSERT : (r < 75) ? CMD_EXTRACT :
                                   (r < 87) ? CMD_PEEK : CMD_MODIFY;
                    default: cmd = (r < 38) ? CMD_INSERT : (r < 70) ? CMD_EXTRACT :
                                   (r < 82) ? CMD_PEEK : CMD_MODIFY;
                endcase
                send_item(cmd, pick_value(), pick_prio());
            end
        end

        drain_results();
        repeat (10) @(posedge i_clk);

        $display("sent %0d insert, %0d extract, %0d peek, %0d modify; %0d results checked",
                 sent_by_cmd[CMD_INSERT], sent_by_cmd[CMD_EXTRACT],
                 sent_by_cmd[CMD_PEEK], sent_by_cmd[CMD_MODIFY], checked);
        $display("queue reported full %0d times and empty %0d times", full_seen, empty_seen);
        if (awaiting != 0)
            $display("%0d predicted results never arrived", awaiting);
        if (errors == 0 && awaiting == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    // Hard stop in case the block hangs
    initial begin
        #5_000_000;
        $display("timeout waiting for the block");
        $display("end of test: mismatches");
        $finish;
    end

endmodule

/* sorted_priority_queue.f */
sv/spq_pkg.sv
sv/spq_if.sv
sv/spq_cell.sv
sv/sorted_priority_queue.sv
verif/spq_checker.sv
verif/sorted_priority_queue_tb.sv
